### src/mcpwm_pkg.sv
// Shared types and constants of the multi-channel PWM generator.
package mcpwm_pkg;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_START   = 2'd1,
        CMD_RELEASE = 2'd2
    } t_command;

    localparam logic [2:0] CFG_DUTY_LOW     = 3'd0;
    localparam logic [2:0] CFG_DUTY_HIGH    = 3'd1;
    localparam logic [2:0] CFG_PIN_MASK     = 3'd2;
    localparam logic [2:0] CFG_PERIOD_US    = 3'd3;
    localparam logic [2:0] CFG_REPEAT_COUNT = 3'd4;
    localparam logic [2:0] CFG_ALLOWED_PINS = 3'd5;

    localparam logic [31:0] PERIOD_MIN   = 32'd500;
    localparam logic [31:0] PERIOD_LIMIT = 32'd2000004000;
    localparam logic [31:0] PERIOD_SLOW  = 32'd10000000;
    localparam logic [31:0] TICKS_PER_US = 32'd80;

    localparam logic [2:0] RELOAD_SETTLE = 3'd5;

    typedef struct packed {
        logic        status;
        logic [15:0] pin_level;
        logic [15:0] pin_drive_enable;
        logic        timer_running;
        logic [29:0] reload_value;
        logic        prescale_code;
    } t_result;

endpackage

### src/multi_channel_pwm_generator.sv
// Multi-channel PWM generator: command decode, pin state, reload pipeline and output skid.
//
// The block takes one command item per cycle while the input is not stalled and returns
// one result item for each, in the cycle after acceptance when the output is free; a skid
// register holds one more result while the output is stalled. The timer reload value
// comes from a five-stage pipeline that follows the period register, so after reset and
// after every write of the period register the input stalls while that pipeline settles.
// All pin updates for an item are made in the single cycle in which it is accepted.
module multi_channel_pwm_generator #(
    parameter int STEPS     = 100,
    parameter int PIN_COUNT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_release_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic [15:0] o_pin_level,
    output logic [15:0] o_pin_drive_enable,
    output logic        o_timer_running,
    output logic [29:0] o_reload_value,
    output logic        o_prescale_code,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam logic [7:0]  STEPS_B     = 8'(STEPS);
    localparam logic [8:0]  STEPS_W     = 9'(STEPS);
    localparam logic [31:0] STEPS_D     = 32'(STEPS);
    localparam logic [15:0] PIN_FIELD   = 16'((32'd1 << PIN_COUNT) - 32'd1);
    localparam logic [63:0] RECIP_FULL  = 64'h1_0000_0000 / 64'(STEPS);
    localparam logic [31:0] RECIP       = RECIP_FULL[31:0];

    // Configuration registers.
    logic [63:0] r_duty_low;
    logic [63:0] r_duty_high;
    logic [15:0] r_pin_mask;
    logic [31:0] r_period_us;
    logic [31:0] r_repeat_count;
    logic [15:0] r_allowed_pins;
    logic [2:0]  r_settle;

    // Generator state.
    logic [7:0]  r_pin_duty [PIN_COUNT];
    logic [7:0]  n_pin_duty [PIN_COUNT];
    logic [15:0] r_used, n_used;
    logic [15:0] r_held, n_held;
    logic [7:0]  r_step, n_step;
    logic [31:0] r_periods_left, n_periods_left;
    logic        r_fell, n_fell;
    logic        r_armed, n_armed;
    logic [15:0] r_level, n_level;
    logic [15:0] r_enable, n_enable;

    // Reload pipeline.
    logic [31:0] r_div_x, r_x2, r_x3;
    logic        r_pre1, r_pre2, r_pre3, r_pre4;
    logic [31:0] r_q0, r_q0_3, r_q0d, r_q;
    logic [29:0] r_reload;
    logic        r_prescale;
    logic [63:0] w_prod;
    logic [31:0] w_rem;
    logic [39:0] w_q80;

    // Output and skid registers.
    mcpwm_pkg::t_result r_out, r_skid, w_result;
    logic               r_out_valid, r_skid_valid;

    logic        w_in_accept;
    logic        w_out_free;
    logic        w_cfg_write;
    logic [127:0] w_duty_regs;
    logic [15:0] w_hit;
    logic [15:0] w_nonzero;
    logic        w_duty_ok;
    logic        w_start_ok;
    logic [15:0] w_mask;
    logic [7:0]  w_cmp;
    logic [8:0]  w_step_inc;
    logic [7:0]  w_step_next;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = r_skid_valid || (r_settle != 3'd0);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out.status;
    assign o_pin_level        = r_out.pin_level;
    assign o_pin_drive_enable = r_out.pin_drive_enable;
    assign o_timer_running    = r_out.timer_running;
    assign o_reload_value     = r_out.reload_value;
    assign o_prescale_code    = r_out.prescale_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty_low     <= '0;
            r_duty_high    <= '0;
            r_pin_mask     <= '0;
            r_period_us    <= 32'd1000;
            r_repeat_count <= '0;
            r_allowed_pins <= 16'hFFFF;
            r_settle       <= mcpwm_pkg::RELOAD_SETTLE;
        end else begin
            if (w_cfg_write) begin
                unique case (i_cfg_index)
                    mcpwm_pkg::CFG_DUTY_LOW:     r_duty_low     <= i_cfg_data;
                    mcpwm_pkg::CFG_DUTY_HIGH:    r_duty_high    <= i_cfg_data;
                    mcpwm_pkg::CFG_PIN_MASK:     r_pin_mask     <= i_cfg_data[15:0];
                    mcpwm_pkg::CFG_PERIOD_US:    r_period_us    <= i_cfg_data[31:0];
                    mcpwm_pkg::CFG_REPEAT_COUNT: r_repeat_count <= i_cfg_data[31:0];
                    mcpwm_pkg::CFG_ALLOWED_PINS: r_allowed_pins <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (w_cfg_write && i_cfg_index == mcpwm_pkg::CFG_PERIOD_US) begin
                r_settle <= mcpwm_pkg::RELOAD_SETTLE;
            end else if (r_settle != 3'd0) begin
                r_settle <= r_settle - 3'd1;
            end
        end
    end

    // Reload = period * 80 / STEPS below the slow limit, else (period / STEPS) * 80 / 256.
    // The division is a reciprocal multiply followed by one correction step.
    assign w_prod = 64'(r_div_x) * 64'(RECIP);
    assign w_rem  = r_x3 - r_q0d;
    assign w_q80  = 40'(r_q) * 40'(mcpwm_pkg::TICKS_PER_US);

    always_ff @(posedge i_clk) begin
        r_pre1  <= r_period_us >= mcpwm_pkg::PERIOD_SLOW;
        r_div_x <= (r_period_us >= mcpwm_pkg::PERIOD_SLOW) ? r_period_us
                 : 32'(r_period_us * mcpwm_pkg::TICKS_PER_US);
        r_q0    <= w_prod[63:32];
        r_x2    <= r_div_x;
        r_pre2  <= r_pre1;
        r_q0d   <= 32'(r_q0 * STEPS_D);
        r_q0_3  <= r_q0;
        r_x3    <= r_x2;
        r_pre3  <= r_pre2;
        r_q     <= r_q0_3 + 32'(w_rem >= STEPS_D);
        r_pre4  <= r_pre3;
        r_reload   <= r_pre4 ? w_q80[37:8] : r_q[29:0];
        r_prescale <= r_pre4;
    end

    assign w_duty_regs = {r_duty_high, r_duty_low};
    assign w_mask      = r_pin_mask & PIN_FIELD;
    assign w_cmp       = (r_step == 8'd0) ? STEPS_B : r_step;
    assign w_step_inc  = {1'b0, r_step} + 9'd1;
    assign w_step_next = (w_step_inc >= STEPS_W) ? 8'd0 : w_step_inc[7:0];

    always_comb begin
        w_hit     = '0;
        w_nonzero = '0;
        w_duty_ok = 1'b1;
        for (int i = 0; i < PIN_COUNT; i++) begin
            w_hit[i]     = r_used[i] && (r_pin_duty[i] == w_cmp);
            w_nonzero[i] = w_duty_regs[8*i +: 8] != 8'd0;
            if (w_duty_regs[8*i +: 8] > STEPS_B) begin
                w_duty_ok = 1'b0;
            end
        end
    end

    assign w_start_ok = ((r_pin_mask & ~r_allowed_pins) == 16'd0) &&
                        (r_period_us >= mcpwm_pkg::PERIOD_MIN) &&
                        (r_period_us < mcpwm_pkg::PERIOD_LIMIT) && w_duty_ok;

    always_comb begin
        n_pin_duty     = r_pin_duty;
        n_used         = r_used;
        n_held         = r_held;
        n_step         = r_step;
        n_periods_left = r_periods_left;
        n_fell         = r_fell;
        n_armed        = r_armed;
        n_level        = r_level;
        n_enable       = r_enable;
        w_result.status        = 1'b0;
        w_result.reload_value  = '0;
        w_result.prescale_code = 1'b0;

        unique case (mcpwm_pkg::t_command'(i_command))
            mcpwm_pkg::CMD_TICK: begin
                if (r_armed) begin
                    if (r_step == 8'd0 && r_periods_left == 32'd1) begin
                        n_periods_left = '0;
                        n_armed        = 1'b0;
                        n_level        = r_level & ~w_hit;
                        n_enable       = r_enable | w_hit;
                        for (int i = 0; i < PIN_COUNT; i++) begin
                            if (r_used[i] || r_held[i]) begin
                                n_pin_duty[i] = '0;
                            end
                        end
                        n_used = '0;
                        n_held = '0;
                    end else if (r_step == 8'd0) begin
                        if (r_periods_left != 32'd0) begin
                            n_periods_left = r_periods_left - 32'd1;
                        end else if (!r_fell) begin
                            n_armed = 1'b0;
                        end
                        n_level  = r_level | r_used;
                        n_enable = r_enable | r_used;
                        n_fell   = 1'b0;
                        n_step   = w_step_next;
                    end else begin
                        if (w_hit != 16'd0) begin
                            n_level  = r_level & ~w_hit;
                            n_enable = r_enable | w_hit;
                            n_fell   = 1'b1;
                        end
                        n_step = w_step_next;
                    end
                end
            end
            mcpwm_pkg::CMD_START: begin
                if (!w_start_ok) begin
                    w_result.status = 1'b1;
                end else begin
                    n_armed        = 1'b0;
                    n_periods_left = r_repeat_count;
                    for (int i = 0; i < PIN_COUNT; i++) begin
                        if (w_mask[i]) begin
                            n_pin_duty[i] = w_duty_regs[8*i +: 8];
                        end
                    end
                    n_used   = (r_used & ~w_mask) | (w_mask & w_nonzero);
                    n_held   = (r_held & ~w_mask) | (w_mask & ~w_nonzero);
                    n_enable = r_enable | n_used | n_held;
                    n_level  = (r_level | n_used) & ~n_held;
                    if (n_used != 16'd0) begin
                        n_fell  = 1'b1;
                        n_step  = 8'd1;
                        n_armed = 1'b1;
                        w_result.reload_value  = r_reload;
                        w_result.prescale_code = r_prescale;
                    end
                end
            end
            mcpwm_pkg::CMD_RELEASE: begin
                for (int i = 0; i < PIN_COUNT; i++) begin
                    if (i_release_mask[i]) begin
                        n_pin_duty[i] = '0;
                    end
                end
                n_used = r_used & ~i_release_mask;
                n_held = r_held & ~i_release_mask;
            end
            default: ;
        endcase

        w_result.pin_level        = n_level;
        w_result.pin_drive_enable = n_enable;
        w_result.timer_running    = n_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIN_COUNT; i++) begin
                r_pin_duty[i] <= '0;
            end
            r_used         <= '0;
            r_held         <= '0;
            r_step         <= '0;
            r_periods_left <= '0;
            r_fell         <= 1'b0;
            r_armed        <= 1'b0;
            r_level        <= '0;
            r_enable       <= '0;
        end else if (w_in_accept) begin
            r_pin_duty     <= n_pin_duty;
            r_used         <= n_used;
            r_held         <= n_held;
            r_step         <= n_step;
            r_periods_left <= n_periods_left;
            r_fell         <= n_fell;
            r_armed        <= n_armed;
            r_level        <= n_level;
            r_enable       <= n_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_accept;
                if (w_in_accept) begin
                    r_out <= w_result;
                end
            end
        end else if (w_in_accept) begin
            r_skid       <= w_result;
            r_skid_valid <= 1'b1;
        end
    end

endmodule

### src/mcpwm_checker.sv
// Port-level checker of the multi-channel PWM generator and its bind statement.
module mcpwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_status,
    input logic [15:0] o_pin_level,
    input logic [15:0] o_pin_drive_enable,
    input logic        o_timer_running,
    input logic [29:0] o_reload_value,
    input logic        o_prescale_code
);

    // A stalled result item holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pin_level) &&
        $stable(o_pin_drive_enable) && $stable(o_reload_value) && $stable(o_status))
        else $error("stalled result item changed");

    // A pin is only driven high once its driver is enabled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pin_level & ~o_pin_drive_enable) == 16'd0)
        else $error("pin high without driver enabled");

    // A reload value is reported only by a start that arms the timer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_reload_value != 30'd0 || o_prescale_code) |->
        o_timer_running && !o_status)
        else $error("reload reported without armed timer");

    // A rejected start never carries a reload value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> o_reload_value == 30'd0 && !o_prescale_code)
        else $error("rejected start carries reload");

endmodule

bind multi_channel_pwm_generator mcpwm_checker u_mcpwm_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multi-channel PWM generator, with a pin-state scoreboard class.
module tb_top;

    localparam int STEPS       = 100;
    localparam int PIN_COUNT   = 16;
    localparam int ITEM_TARGET = 2000;
    localparam int QUIET_TAIL  = 1800;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] CFG_UNMAPPED = 3'd7;

    class pwm_state;
        logic [63:0] duty_low_reg;
        logic [63:0] duty_high_reg;
        logic [15:0] pin_mask_reg;
        logic [31:0] period_reg;
        logic [31:0] repeat_reg;
        logic [15:0] allowed_reg;

        logic [7:0]  pin_duty [16];
        logic [15:0] used_pins;
        logic [15:0] held_low_pins;
        int unsigned step_idx;
        logic [31:0] periods_left;
        bit          fell;
        bit          armed;
        logic [15:0] level_reg;
        logic [15:0] enable_reg;

        mcpwm_pkg::t_result pending_results [$];
        int unsigned        errors;

        function new();
            duty_low_reg  = '0;
            duty_high_reg = '0;
            pin_mask_reg  = '0;
            period_reg    = 32'd1000;
            repeat_reg    = '0;
            allowed_reg   = 16'hFFFF;
            foreach (pin_duty[i]) pin_duty[i] = '0;
            used_pins     = '0;
            held_low_pins = '0;
            step_idx      = 0;
            periods_left  = '0;
            fell          = 1'b0;
            armed         = 1'b0;
            level_reg     = '0;
            enable_reg    = '0;
            errors        = 0;
        endfunction

        function void write_config(logic [2:0] idx, logic [63:0] data);
            case (idx)
                mcpwm_pkg::CFG_DUTY_LOW:     duty_low_reg = data;
                mcpwm_pkg::CFG_DUTY_HIGH:    duty_high_reg = data;
                mcpwm_pkg::CFG_PIN_MASK:     pin_mask_reg = data[15:0];
                mcpwm_pkg::CFG_PERIOD_US:    period_reg = data[31:0];
                mcpwm_pkg::CFG_REPEAT_COUNT: repeat_reg = data[31:0];
                mcpwm_pkg::CFG_ALLOWED_PINS: allowed_reg = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] reg_duty(int pin);
            if (pin < 8) begin
                return duty_low_reg[8*pin +: 8];
            end
            return duty_high_reg[8*(pin-8) +: 8];
        endfunction

        function void drop_pins(logic [15:0] mask);
            for (int i = 0; i < 16; i++) begin
                if (mask[i]) pin_duty[i] = '0;
            end
            used_pins     &= ~mask;
            held_low_pins &= ~mask;
        endfunction

        function logic [15:0] pins_at(int unsigned step_val);
            logic [15:0] p;
            p = '0;
            for (int i = 0; i < PIN_COUNT; i++) begin
                if (used_pins[i] && pin_duty[i] == step_val) p[i] = 1'b1;
            end
            return p;
        endfunction

        function void tick();
            logic [15:0] p;
            if (!armed) return;
            if (step_idx == 0) begin
                if (periods_left != 0) begin
                    periods_left--;
                    if (periods_left == 0) begin
                        armed = 1'b0;
                        p = pins_at(STEPS);
                        level_reg  &= ~p;
                        enable_reg |= p;
                        drop_pins(used_pins | held_low_pins);
                        return;
                    end
                end else if (!fell) begin
                    armed = 1'b0;
                end
                level_reg  |= used_pins;
                enable_reg |= used_pins;
                fell = 1'b0;
            end else begin
                p = pins_at(step_idx);
                if (p != 0) begin
                    level_reg  &= ~p;
                    enable_reg |= p;
                    fell = 1'b1;
                end
            end
            step_idx++;
            if (step_idx >= STEPS) step_idx = 0;
        endfunction

        function bit start_run(output logic [29:0] reload, output logic pre);
            logic [15:0] mask;
            logic [63:0] t;
            reload = '0;
            pre    = 1'b0;
            mask   = pin_mask_reg & 16'((32'd1 << PIN_COUNT) - 1);
            if ((pin_mask_reg & ~allowed_reg) != 0 ||
                    period_reg < mcpwm_pkg::PERIOD_MIN ||
                    period_reg >= mcpwm_pkg::PERIOD_LIMIT) begin
                return 1'b1;
            end
            for (int i = 0; i < PIN_COUNT; i++) begin
                if (reg_duty(i) > STEPS) return 1'b1;
            end
            armed = 1'b0;
            periods_left = repeat_reg;
            drop_pins(mask);
            for (int i = 0; i < PIN_COUNT; i++) begin
                if (mask[i]) begin
                    if (reg_duty(i) != 0) begin
                        pin_duty[i]  = reg_duty(i);
                        used_pins[i] = 1'b1;
                    end else begin
                        held_low_pins[i] = 1'b1;
                    end
                end
            end
            enable_reg |= used_pins | held_low_pins;
            level_reg = (level_reg | used_pins) & ~held_low_pins;
            if (used_pins != 0) begin
                fell     = 1'b1;
                step_idx = 1;
                armed    = 1'b1;
                if (period_reg < mcpwm_pkg::PERIOD_SLOW) begin
                    t = {32'd0, period_reg} * 64'(mcpwm_pkg::TICKS_PER_US) / 64'(STEPS);
                end else begin
                    t = ({32'd0, period_reg} / 64'(STEPS)) *
                        64'(mcpwm_pkg::TICKS_PER_US) / 64'd256;
                    pre = 1'b1;
                end
                if (t > 64'h3FFF_FFFF) t = 64'h3FFF_FFFF;
                reload = t[29:0];
            end
            return 1'b0;
        endfunction

        function void apply_command(logic [1:0] cmd, logic [15:0] rel);
            mcpwm_pkg::t_result r;
            logic [29:0]        rl;
            logic               pr;
            r  = '0;
            rl = '0;
            pr = 1'b0;
            case (cmd)
                mcpwm_pkg::CMD_TICK:    tick();
                mcpwm_pkg::CMD_START:   r.status = start_run(rl, pr);
                mcpwm_pkg::CMD_RELEASE: drop_pins(rel);
                default: ;
            endcase
            r.pin_level        = level_reg;
            r.pin_drive_enable = enable_reg;
            r.timer_running    = armed;
            r.reload_value     = rl;
            r.prescale_code    = pr;
            pending_results.push_back(r);
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, name,
                             want, got);
                end
            end
        endfunction

        function void check_result(mcpwm_pkg::t_result got);
            mcpwm_pkg::t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("%0t: result item with none expected", $realtime);
                return;
            end
            want = pending_results.pop_front();
            compare("status", want.status, got.status);
            compare("pin_level", want.pin_level, got.pin_level);
            compare("pin_drive_enable", want.pin_drive_enable, got.pin_drive_enable);
            compare("timer_running", want.timer_running, got.timer_running);
            compare("reload_value", want.reload_value, got.reload_value);
            compare("prescale_code", want.prescale_code, got.prescale_code);
        endfunction

        function void check_leftover();
            if (pending_results.size() != 0) begin
                errors += pending_results.size();
                $display("%0d result items never arrived", pending_results.size());
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [15:0] i_release_mask;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_status;
    logic [15:0] o_pin_level;
    logic [15:0] o_pin_drive_enable;
    logic        o_timer_running;
    logic [29:0] o_reload_value;
    logic        o_prescale_code;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    pwm_state    shadow;
    bit          idle_on;
    bit          hold_req;
    int unsigned useful_items;
    int unsigned quiet_cycles;
    int unsigned phase;

    multi_channel_pwm_generator #(
        .STEPS     (STEPS),
        .PIN_COUNT (PIN_COUNT)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_release_mask     (i_release_mask),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_pin_level        (o_pin_level),
        .o_pin_drive_enable (o_pin_drive_enable),
        .o_timer_running    (o_timer_running),
        .o_reload_value     (o_reload_value),
        .o_prescale_code    (o_prescale_code),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                shadow.check_result({o_status, o_pin_level, o_pin_drive_enable,
                                     o_timer_running, o_reload_value, o_prescale_code});
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                    (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_stall = 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [15:0] rel);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 9) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_command      = cmd;
        i_release_mask = rel;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd != mcpwm_pkg::CMD_TICK || shadow.armed) useful_items++;
        shadow.apply_command(cmd, rel);
    endtask

    task automatic input_quiet();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow.write_config(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (shadow.pending_results.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_duty_word();
        logic [63:0] w;
        int          k;
        for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 5))
                0:       w[8*k +: 8] = 8'd0;
                1:       w[8*k +: 8] = 8'(STEPS);
                2:       w[8*k +: 8] = 8'd1;
                3:       w[8*k +: 8] = 8'(STEPS - 1);
                default: w[8*k +: 8] = 8'($urandom_range(0, STEPS));
            endcase
        end
        if ($urandom_range(0, 11) == 0) begin
            k = $urandom_range(0, 7);
            w[8*k +: 8] = 8'($urandom_range(STEPS + 1, 255));
        end
        return w;
    endfunction

    function automatic logic [15:0] rand_pins();
        case ($urandom_range(0, 4))
            0:       return 16'hFFFF;
            1:       return 16'd1 << $urandom_range(0, 15);
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [15:0] mask;
        logic [31:0] period;
        logic [31:0] count;
        mask = shadow.pin_mask_reg;
        if ($urandom_range(0, 3) != 0) write_reg(mcpwm_pkg::CFG_DUTY_LOW, rand_duty_word());
        if ($urandom_range(0, 3) != 0) write_reg(mcpwm_pkg::CFG_DUTY_HIGH, rand_duty_word());
        if ($urandom_range(0, 3) != 0) begin
            mask = rand_pins();
            write_reg(mcpwm_pkg::CFG_PIN_MASK, {32'($urandom), 16'($urandom), mask});
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 9))
                0:       period = mcpwm_pkg::PERIOD_MIN;
                1:       period = mcpwm_pkg::PERIOD_LIMIT - 1;
                2:       period = mcpwm_pkg::PERIOD_SLOW - 1;
                3:       period = mcpwm_pkg::PERIOD_SLOW;
                7:       period = $urandom_range(mcpwm_pkg::PERIOD_SLOW,
                                                 mcpwm_pkg::PERIOD_LIMIT - 1);
                8:       period = $urandom_range(0, mcpwm_pkg::PERIOD_MIN - 1);
                9:       period = $urandom_range(mcpwm_pkg::PERIOD_LIMIT, 32'hFFFF_FFFF);
                default: period = $urandom_range(mcpwm_pkg::PERIOD_MIN, 50000);
            endcase
            write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'($urandom), period});
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 6))
                3:       count = 32'd1;
                4:       count = $urandom_range(2, 3);
                5:       count = 32'hFFFF_FFFF;
                6:       count = $urandom;
                default: count = 32'd0;
            endcase
            write_reg(mcpwm_pkg::CFG_REPEAT_COUNT, {32'($urandom), count});
        end
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
                0:       write_reg(mcpwm_pkg::CFG_ALLOWED_PINS, {48'($urandom), 16'hFFFF});
                1:       write_reg(mcpwm_pkg::CFG_ALLOWED_PINS,
                                   {48'd0, 16'($urandom) | mask});
                default: write_reg(mcpwm_pkg::CFG_ALLOWED_PINS, {48'd0, 16'($urandom)});
            endcase
        end
    endtask

    task automatic run_phase(input bit pause_midway);
        int n;
        int k;
        int idle_ticks;
        n = $urandom_range(60, 330);
        idle_ticks = 0;
        send_item(mcpwm_pkg::CMD_START, 16'($urandom));
        for (k = 0; k < n && idle_ticks < 4; k++) begin
            if (pause_midway && k == n / 2) begin
                input_quiet();
                wait_drained();
            end
            case ($urandom_range(0, 39))
                0:       send_item(mcpwm_pkg::CMD_RELEASE, rand_pins());
                1:       send_item(mcpwm_pkg::CMD_RELEASE, 16'($urandom));
                2:       send_item(CMD_UNUSED, 16'($urandom));
                3:       send_item(mcpwm_pkg::CMD_START, 16'($urandom));
                default: send_item(mcpwm_pkg::CMD_TICK, 16'($urandom));
            endcase
            if (!shadow.armed) idle_ticks++;
        end
        input_quiet();
    endtask

    task automatic directed_checks();
        send_item(mcpwm_pkg::CMD_TICK, 16'h0000);
        send_item(CMD_UNUSED, 16'hFFFF);
        send_item(mcpwm_pkg::CMD_RELEASE, 16'hFFFF);
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        input_quiet();
        wait_drained();
        write_reg(mcpwm_pkg::CFG_ALLOWED_PINS, 64'h0000_0000_0000_00FF);
        write_reg(mcpwm_pkg::CFG_PIN_MASK, 64'h0000_0000_0000_FF00);
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        input_quiet();
        wait_drained();
        write_reg(mcpwm_pkg::CFG_ALLOWED_PINS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'd0, mcpwm_pkg::PERIOD_MIN - 1});
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        input_quiet();
        wait_drained();
        write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'd0, mcpwm_pkg::PERIOD_LIMIT});
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        input_quiet();
        wait_drained();
        write_reg(CFG_UNMAPPED, {$urandom, $urandom});
        write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'd0, mcpwm_pkg::PERIOD_MIN});
        write_reg(mcpwm_pkg::CFG_DUTY_LOW, 64'h0000_0000_6500_0000);
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        input_quiet();
        wait_drained();
        write_reg(mcpwm_pkg::CFG_DUTY_LOW, 64'h3232_3232_6301_0064);
        write_reg(mcpwm_pkg::CFG_DUTY_HIGH, 64'h0100_0000_0000_0064);
        write_reg(mcpwm_pkg::CFG_PIN_MASK, 64'h0000_0000_0000_FFFF);
        write_reg(mcpwm_pkg::CFG_REPEAT_COUNT, 64'h0000_0000_0000_0001);
        write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'd0, mcpwm_pkg::PERIOD_LIMIT - 1});
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        repeat (4) send_item(mcpwm_pkg::CMD_TICK, 16'($urandom));
        send_item(mcpwm_pkg::CMD_RELEASE, 16'h0004);
        send_item(mcpwm_pkg::CMD_TICK, 16'hFFFF);
        input_quiet();
        wait_drained();
        write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'd0, mcpwm_pkg::PERIOD_SLOW - 1});
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        send_item(mcpwm_pkg::CMD_TICK, 16'h0000);
        input_quiet();
        wait_drained();
        write_reg(mcpwm_pkg::CFG_PERIOD_US, {32'd0, mcpwm_pkg::PERIOD_SLOW});
        send_item(mcpwm_pkg::CMD_START, 16'h0000);
        send_item(mcpwm_pkg::CMD_TICK, 16'h0000);
        input_quiet();
        wait_drained();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = mcpwm_pkg::CMD_TICK;
        i_release_mask = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = mcpwm_pkg::CFG_DUTY_LOW;
        i_cfg_data     = '0;
        idle_on        = 1'b1;
        hold_req       = 1'b0;
        useful_items   = 0;
        quiet_cycles   = 0;
        shadow         = new();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_checks();

        phase = 0;
        while (useful_items < ITEM_TARGET) begin
            if (useful_items >= QUIET_TAIL) begin
                idle_on = 1'b0;
            end else begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            random_config();
            if (phase == 2) hold_req = 1'b1;
            run_phase(phase == 4);
            wait_drained();
            phase++;
        end

        repeat (20) @(posedge i_clk);
        shadow.check_leftover();
        if (shadow.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
